FILE: rtl/lumroi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lumroi_pkg
// Shared widths, register indexes, reset values and arithmetic constants of
// the luma unsharp mask block.
// ----------------------------------------------------------------------------
package lumroi_pkg;

    localparam int PIX_W         = 16;
    localparam int LUMA_W        = 8;
    localparam int CNT_W         = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 26;
    localparam int DEF_MAX_WIDTH = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_COLUMNS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_ROWS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_LANE    = 3'd7;

    // reset values
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [8:0]  RST_STRENGTH     = 9'd128;
    localparam logic [8:0]  RST_BG_SCALE     = 9'd256;

    // 9 * 65536 denominator of the sharpened value
    localparam logic [31:0] SHARP_HALF  = 32'd294912;
    localparam logic [31:0] SHARP_SAT   = 32'd150405120;
    localparam logic [12:0] DIV9_RECIP  = 13'd7282;
    localparam logic [17:0] P_MIN       = 18'd512;

    typedef struct packed {
        logic             has0;
        logic             has1;
        logic             last1;
        logic             pos;
        logic [PIX_W-1:0] w0;
        logic [PIX_W-1:0] w1;
    } t_meta;

endpackage
`default_nettype wire

FILE: rtl/lumroi_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lumroi stream interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lumroi_pix_in_if;
    logic                         valid;
    logic                         ready;
    logic [lumroi_pkg::PIX_W-1:0] pixel_word;
    logic                         flush;

    modport source (output valid, output pixel_word, output flush, input ready);
    modport sink   (input valid, input pixel_word, input flush, output ready);
endinterface

interface lumroi_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [lumroi_pkg::PIX_W-1:0] pixel_out;
    logic                         last_of_frame;

    modport source (output valid, output pixel_out, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface
`default_nettype wire

FILE: rtl/luma_unsharp_mask_roi_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luma_unsharp_mask_roi_core
// 3x3 box unsharp mask on the luma byte of a raster YUV422 stream, with a
// region of interest and two line stores in block memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_pix    in   valid/ready    pixel_word[15:0], flush
//  o_pix    out  valid/ready    pixel_out[15:0], last_of_frame
//  i_cfg    in   write enable   i_cfg_idx[2:0], i_cfg_data[25:0]
//
//  One item per clock; the limit is the single read-write pass over the
//  line store entry of the current column. Items pass the stage registers,
//  then the output buffer. The last item of a row gives up to two results;
//  they fit the two-entry output buffer, so no stall unless o_pix stalls.
//  When o_pix stalls and the output buffer cannot take the results of the
//  last stage, the whole pipeline freezes and i_pix.ready drops.
//  Reset clears counters, window and pipeline; line stores are not cleared.
// ----------------------------------------------------------------------------
module luma_unsharp_mask_roi_core #(
    parameter int MAX_WIDTH = lumroi_pkg::DEF_MAX_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    lumroi_pix_in_if.sink                       i_pix,
    lumroi_pix_out_if.source                    o_pix,
    input  wire                                 i_cfg_we,
    input  wire [lumroi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [lumroi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = lumroi_pkg::PIX_W;
    localparam int CW = lumroi_pkg::CNT_W;

    // configuration
    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [8:0]  r_strength;
    logic [8:0]  r_bg_scale;
    logic [15:0] r_thresholds;
    logic [25:0] r_roi_columns;
    logic [25:0] r_roi_rows;
    logic        r_luma_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lumroi_pkg::RST_FRAME_WIDTH;
            r_frame_height <= lumroi_pkg::RST_FRAME_HEIGHT;
            r_strength     <= lumroi_pkg::RST_STRENGTH;
            r_bg_scale     <= lumroi_pkg::RST_BG_SCALE;
            r_thresholds   <= '0;
            r_roi_columns  <= '0;
            r_roi_rows     <= '0;
            r_luma_lane    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lumroi_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[12:0];
                lumroi_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                lumroi_pkg::CFG_STRENGTH:     r_strength     <= i_cfg_data[8:0];
                lumroi_pkg::CFG_BG_SCALE:     r_bg_scale     <= i_cfg_data[8:0];
                lumroi_pkg::CFG_THRESHOLDS:   r_thresholds   <= i_cfg_data[15:0];
                lumroi_pkg::CFG_ROI_COLUMNS:  r_roi_columns  <= i_cfg_data[25:0];
                lumroi_pkg::CFG_ROI_ROWS:     r_roi_rows     <= i_cfg_data[25:0];
                lumroi_pkg::CFG_LUMA_LANE:    r_luma_lane    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [7:0] luma_of(input logic [PW-1:0] w, input logic lane);
        return lane ? w[15:8] : w[7:0];
    endfunction

    function automatic logic [PW-1:0] with_luma(input logic [PW-1:0] w,
                                                input logic [7:0] y,
                                                input logic lane);
        return lane ? {y, w[7:0]} : {w[15:8], y};
    endfunction

    // pipeline control
    logic en;
    logic accept;

    // ---------------------------------------------------------------- stage 0
    logic [CW-1:0] r_col, r_row;
    logic [CW-1:0] w_eff, h_eff, w_last, c, r, x, y;
    logic          drain, row_end;
    logic [PW-1:0] word;
    logic [AW-1:0] a_c, a_p;
    logic          focus, pos, has0, has1;
    logic [12:0]   roi_l, roi_r, roi_t, roi_b;

    always_comb begin
        if (r_frame_width == 13'd0) begin
            w_eff = 13'd1;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        h_eff   = (r_frame_height == 13'd0) ? 13'd1 : r_frame_height;
        w_last  = w_eff - 13'd1;
        c       = (r_col > w_last) ? w_last : r_col;
        r       = (r_row > h_eff) ? h_eff : r_row;
        drain   = (r == h_eff);
        row_end = (c == w_last);
        word    = drain ? '0 : i_pix.pixel_word;
        x       = c - 13'd1;
        y       = r - 13'd1;
        a_c     = c[AW-1:0];
        a_p     = (c != 13'd0) ? x[AW-1:0] : '0;
        has0    = (r != 13'd0) && (c != 13'd0);
        has1    = (r != 13'd0) && row_end;
        pos     = (c >= 13'd2) && (r >= 13'd2) && (r < h_eff);
        roi_l   = r_roi_columns[12:0];
        roi_r   = r_roi_columns[25:13];
        roi_t   = r_roi_rows[12:0];
        roi_b   = r_roi_rows[25:13];
        focus   = (roi_r > roi_l) && (roi_b > roi_t) && (x >= roi_l) && (x < roi_r)
                  && (y >= roi_t) && (y < roi_b);
    end

    assign accept      = i_pix.valid && en;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= drain ? '0 : r + 13'd1;
            end else begin
                r_col <= c + 13'd1;
                r_row <= r;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;
    logic [PW-1:0] r_s1_word;
    logic          r_s1_has0, r_s1_has1, r_s1_last1, r_s1_pos, r_s1_focus;
    logic          r_fwd_c, r_fwd_p;
    logic [PW-1:0] r_fwd_u, r_fwd_m;
    logic [PW-1:0] r_rd_uc, r_rd_up, r_rd_m;
    logic [PW-1:0] s1_up, s1_mid, s1_uprev;
    logic          s1_wr;

    logic [PW-1:0] mem_u [0:MAX_WIDTH-1];
    logic [PW-1:0] mem_m [0:MAX_WIDTH-1];

    assign s1_wr    = r_s1_valid && en;
    assign s1_up    = r_fwd_c ? r_fwd_u : r_rd_uc;
    assign s1_mid   = r_fwd_c ? r_fwd_m : r_rd_m;
    assign s1_uprev = r_fwd_p ? r_fwd_u : r_rd_up;

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            mem_u[r_s1_addr] <= s1_mid;
            mem_m[r_s1_addr] <= r_s1_word;
        end
        if (accept) begin
            r_rd_uc <= mem_u[a_c];
            r_rd_up <= mem_u[a_p];
            r_rd_m  <= mem_m[a_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= a_c;
            r_s1_word  <= word;
            r_s1_has0  <= has0;
            r_s1_has1  <= has1;
            r_s1_last1 <= drain;
            r_s1_pos   <= pos;
            r_s1_focus <= focus;
            // same-entry write from the item ahead lands on this read edge
            r_fwd_c    <= s1_wr && (r_s1_addr == a_c);
            r_fwd_p    <= s1_wr && (r_s1_addr == a_p) && (c != 13'd0);
            r_fwd_u    <= s1_mid;
            r_fwd_m    <= r_s1_word;
        end
    end

    // 3x3 luma window, column 2 newest
    logic [7:0] r_win [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_wr) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= luma_of(s1_up, r_luma_lane);
            r_win[1][2] <= luma_of(s1_mid, r_luma_lane);
            r_win[2][2] <= luma_of(r_s1_word, r_luma_lane);
        end
    end

    logic [17:0] s1_p;
    assign s1_p = r_s1_focus ? {1'b0, r_strength, 8'd0}
                             : 18'(r_strength) * 18'(r_bg_scale);

    // ---------------------------------------------------------------- stage 2
    logic              r_s2_valid;
    lumroi_pkg::t_meta r_s2_meta;
    logic [17:0]       r_s2_p;
    logic [7:0]        r_s2_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_meta <= '{has0: r_s1_has0, has1: r_s1_has1, last1: r_s1_last1,
                           pos: r_s1_pos, w0: s1_uprev, w1: s1_mid};
            r_s2_p    <= s1_p;
            r_s2_thr  <= r_s1_focus ? r_thresholds[7:0] : r_thresholds[15:8];
        end
    end

    logic [9:0]         row_sum0, row_sum1, row_sum2;
    logic [11:0]        sum9, yc9;
    logic signed [12:0] s2_d;
    logic               s2_skip;

    always_comb begin
        row_sum0 = 10'(r_win[0][0]) + 10'(r_win[0][1]) + 10'(r_win[0][2]);
        row_sum1 = 10'(r_win[1][0]) + 10'(r_win[1][1]) + 10'(r_win[1][2]);
        row_sum2 = 10'(r_win[2][0]) + 10'(r_win[2][1]) + 10'(r_win[2][2]);
        sum9     = 12'(row_sum0) + 12'(row_sum1) + 12'(row_sum2);
        yc9      = 12'({4'd0, r_win[1][1]} * 12'd9);
        s2_d     = $signed({1'b0, yc9}) - $signed({1'b0, sum9});
        s2_skip  = !r_s2_meta.pos || (r_s2_p <= lumroi_pkg::P_MIN)
                   || (r_win[1][1] <= r_s2_thr);
    end

    // ---------------------------------------------------------------- stage 3
    logic               r_s3_valid;
    lumroi_pkg::t_meta  r_s3_meta;
    logic [17:0]        r_s3_p;
    logic [11:0]        r_s3_yc9;
    logic signed [12:0] r_s3_d;
    logic               r_s3_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_meta <= r_s2_meta;
            r_s3_p    <= r_s2_p;
            r_s3_yc9  <= yc9;
            r_s3_d    <= s2_d;
            r_s3_skip <= s2_skip;
        end
    end

    logic signed [31:0] d_ext, p_ext, s3_n;

    always_comb begin
        d_ext = 32'(r_s3_d);
        p_ext = $signed({14'd0, r_s3_p});
        s3_n  = $signed({4'd0, r_s3_yc9, 16'd0}) + d_ext * p_ext;
    end

    // ---------------------------------------------------------------- stage 4
    logic               r_s4_valid;
    lumroi_pkg::t_meta  r_s4_meta;
    logic signed [31:0] r_s4_n;
    logic               r_s4_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_meta <= r_s3_meta;
            r_s4_n    <= s3_n;
            r_s4_skip <= r_s3_skip;
        end
    end

    logic [31:0] n_round;
    logic [11:0] v;
    logic [24:0] q_full;
    logic [7:0]  q;

    always_comb begin
        n_round = $unsigned(r_s4_n) + lumroi_pkg::SHARP_HALF;
        v       = n_round[27:16];
        q_full  = 25'(v) * 25'(lumroi_pkg::DIV9_RECIP);
        if (r_s4_n[31]) begin
            q = 8'd0;
        end else if ($unsigned(r_s4_n) > lumroi_pkg::SHARP_SAT) begin
            q = 8'd255;
        end else begin
            q = q_full[23:16];
        end
    end

    // ---------------------------------------------------------- output buffer
    logic [PW-1:0] r_ob_word [0:1];
    logic          r_ob_last [0:1];
    logic [1:0]    r_ob_cnt;
    logic [PW-1:0] n_ob_word [0:1];
    logic          n_ob_last [0:1];
    logic [1:0]    n_ob_cnt;
    logic          fire, load, load_ok;
    logic [1:0]    cnt_a, nres;
    logic [PW-1:0] res0_word, first_word;
    logic          first_last;

    always_comb begin
        fire       = (r_ob_cnt != 2'd0) && o_pix.ready;
        cnt_a      = r_ob_cnt - {1'b0, fire};
        nres       = {1'b0, r_s4_meta.has0} + {1'b0, r_s4_meta.has1};
        load_ok    = ({1'b0, cnt_a} + {1'b0, nres}) <= 3'd2;
        en         = !r_s4_valid || load_ok;
        load       = r_s4_valid && load_ok && (nres != 2'd0);
        res0_word  = r_s4_skip ? r_s4_meta.w0 : with_luma(r_s4_meta.w0, q, r_luma_lane);
        first_word = r_s4_meta.has0 ? res0_word : r_s4_meta.w1;
        first_last = r_s4_meta.has0 ? 1'b0 : r_s4_meta.last1;

        n_ob_word[0] = fire ? r_ob_word[1] : r_ob_word[0];
        n_ob_last[0] = fire ? r_ob_last[1] : r_ob_last[0];
        n_ob_word[1] = r_ob_word[1];
        n_ob_last[1] = r_ob_last[1];
        n_ob_cnt     = cnt_a;
        if (load) begin
            n_ob_cnt = cnt_a + nres;
            if (cnt_a == 2'd0) begin
                n_ob_word[0] = first_word;
                n_ob_last[0] = first_last;
                n_ob_word[1] = r_s4_meta.w1;
                n_ob_last[1] = r_s4_meta.last1;
            end else begin
                n_ob_word[1] = first_word;
                n_ob_last[1] = first_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else begin
            r_ob_cnt <= n_ob_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob_word[0] <= n_ob_word[0];
        r_ob_word[1] <= n_ob_word[1];
        r_ob_last[0] <= n_ob_last[0];
        r_ob_last[1] <= n_ob_last[1];
    end

    assign o_pix.valid         = (r_ob_cnt != 2'd0);
    assign o_pix.pixel_out     = r_ob_word[0];
    assign o_pix.last_of_frame = r_ob_last[0];

    // ------------------------------------------------------------- assertions
    a_drain_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && drain && row_end |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not return to zero after the drain row");

    a_s4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && !en |=> r_s4_valid && $stable(r_s4_n) && $stable(r_s4_meta))
        else $error("stalled last stage changed");

    a_ob_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_cnt == 2'd2) && !o_pix.ready |-> !load)
        else $error("output buffer loaded while full");

    a_ob_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_ob_cnt != 2'd0) && (r_ob_cnt != 2'd3))
        else $error("output buffer count out of range after load");

endmodule
`default_nettype wire

FILE: tb/lumroi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lumroi_checker
// Watches the pixel channels and the register port of the unsharp mask core.
// Tracks its own copy of the line stores, 3x3 luma window, raster counters
// and registers, predicts the result pixels of every accepted item, and
// compares each accepted result item with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module lumroi_checker
    import lumroi_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    lumroi_pix_in_if             i_pix,
    lumroi_pix_out_if            i_res,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint DEN      = 589824;
    localparam int     REPORT_N = 10;

    typedef struct packed {
        logic [PIX_W-1:0] word;
        logic             last;
    } pixel_result_t;

    pixel_result_t     pixels_due [$];

    logic [PIX_W-1:0]  upper_row  [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]  middle_row [DEF_MAX_WIDTH];
    logic [LUMA_W-1:0] luma_win   [3][3];
    int unsigned       col_pos;
    int unsigned       row_pos;

    logic [12:0]       cfg_width;
    logic [12:0]       cfg_height;
    logic [8:0]        cfg_strength;
    logic [8:0]        cfg_bg_scale;
    logic [15:0]       cfg_thresholds;
    logic [25:0]       cfg_roi_cols;
    logic [25:0]       cfg_roi_rows;
    logic              cfg_lane;

    initial begin
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    function automatic logic [LUMA_W-1:0] luma_byte(input logic [PIX_W-1:0] w);
        return cfg_lane ? w[15:8] : w[7:0];
    endfunction

    function automatic logic [PIX_W-1:0] put_luma(input logic [PIX_W-1:0] w,
                                                  input logic [LUMA_W-1:0] y);
        return cfg_lane ? {y, w[7:0]} : {w[15:8], y};
    endfunction

    function automatic logic [LUMA_W-1:0] sharpened_luma(input int unsigned x,
                                                         input int unsigned y);
        int unsigned left, right, top, bottom, s, b, p, thr;
        bit          focus;
        longint      yc, sum, d, n;
        left   = cfg_roi_cols[12:0];
        right  = cfg_roi_cols[25:13];
        top    = cfg_roi_rows[12:0];
        bottom = cfg_roi_rows[25:13];
        focus  = right > left && bottom > top &&
                 x >= left && x < right && y >= top && y < bottom;
        s   = cfg_strength;
        b   = focus ? 256 : cfg_bg_scale;
        p   = s * b;
        thr = focus ? cfg_thresholds[7:0] : cfg_thresholds[15:8];
        yc  = luma_win[1][1];
        if (p <= 512 || yc <= thr) return luma_win[1][1];
        sum = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                sum += luma_win[i][j];
        d = 9 * yc - sum;
        n = DEN * yc + d * longint'(p);
        if (n < 0) return 8'd0;
        if (n > 255 * DEN) return 8'd255;
        return LUMA_W'((n + DEN / 2) / DEN);
    endfunction

    // one raster step: shift the window, rotate the line stores, queue results
    task automatic advance_raster(input logic [PIX_W-1:0] in_word);
        int unsigned      w, h, c, r, y;
        bit               drain;
        logic [PIX_W-1:0] word, up, mid;
        pixel_result_t    res;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        h = cfg_height;
        if (h < 1) h = 1;
        c = col_pos;
        if (c > w - 1) c = w - 1;
        r = row_pos;
        if (r > h) r = h;
        drain = (r == h);
        word  = drain ? '0 : in_word;

        for (int k = 0; k < 3; k++) begin
            luma_win[k][0] = luma_win[k][1];
            luma_win[k][1] = luma_win[k][2];
        end
        up  = upper_row[c];
        mid = middle_row[c];
        luma_win[0][2] = luma_byte(up);
        luma_win[1][2] = luma_byte(mid);
        luma_win[2][2] = luma_byte(word);
        upper_row[c]   = mid;
        middle_row[c]  = word;

        if (r >= 1) begin
            y = r - 1;
            if (c >= 1) begin
                res.word = upper_row[c - 1];
                res.last = 1'b0;
                if (c >= 2 && y >= 1 && y + 1 < h)
                    res.word = put_luma(res.word, sharpened_luma(c - 1, y));
                pixels_due.push_back(res);
            end
            if (c == w - 1) begin
                res.word = upper_row[c];
                res.last = drain;
                pixels_due.push_back(res);
            end
        end

        if (c == w - 1) begin
            col_pos = 0;
            row_pos = drain ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        pixel_result_t exp_pix;
        pixel_result_t got_pix;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    luma_win[i][j] = '0;
            col_pos        = 0;
            row_pos        = 0;
            cfg_width      = RST_FRAME_WIDTH;
            cfg_height     = RST_FRAME_HEIGHT;
            cfg_strength   = RST_STRENGTH;
            cfg_bg_scale   = RST_BG_SCALE;
            cfg_thresholds = '0;
            cfg_roi_cols   = '0;
            cfg_roi_rows   = '0;
            cfg_lane       = 1'b0;
            pixels_due.delete();
            o_fail_count   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  cfg_width      = i_cfg_data[12:0];
                    CFG_FRAME_HEIGHT: cfg_height     = i_cfg_data[12:0];
                    CFG_STRENGTH:     cfg_strength   = i_cfg_data[8:0];
                    CFG_BG_SCALE:     cfg_bg_scale   = i_cfg_data[8:0];
                    CFG_THRESHOLDS:   cfg_thresholds = i_cfg_data[15:0];
                    CFG_ROI_COLUMNS:  cfg_roi_cols   = i_cfg_data[25:0];
                    CFG_ROI_ROWS:     cfg_roi_rows   = i_cfg_data[25:0];
                    CFG_LUMA_LANE:    cfg_lane       = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                advance_raster(i_pix.pixel_word);
            if (i_res.valid && i_res.ready) begin
                got_pix.word = i_res.pixel_out;
                got_pix.last = i_res.last_of_frame;
                if (pixels_due.size() == 0) begin
                    if (o_fail_count < REPORT_N)
                        $display("checker: result %h last %b with no pixel due",
                                 got_pix.word, got_pix.last);
                    o_fail_count++;
                end else begin
                    exp_pix = pixels_due.pop_front();
                    if (got_pix != exp_pix) begin
                        if (o_fail_count < REPORT_N)
                            $display("checker: mismatch expected %h last %b, got %h last %b",
                                     exp_pix.word, exp_pix.last,
                                     got_pix.word, got_pix.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raster frames into the luma unsharp mask core: a short directed set
// of tiny frames, randomly configured small frames under several idle and
// stall patterns with a long output hold-off and a drain pause, a mid-frame
// size shrink, an oversize width cut short in mid-row and a zero-width frame.
// The checker beside the core predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
    import lumroi_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 580;
    localparam int MIN_FRAMES    = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [PIX_W-1:0] EDGE_WORDS [12] = '{
        16'h0000, 16'hFFFF, 16'h80FF, 16'h7F00,
        16'hFF10, 16'h5580, 16'hAAF0, 16'h0001,
        16'hFFFE, 16'h00FF, 16'h1234, 16'hFFFF
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int random_items   = 0;
    int unsigned cur_w_raw = 640;
    int unsigned cur_h_raw = 480;
    logic        cur_lane  = 1'b0;

    lumroi_pix_in_if  pix_in_bus ();
    lumroi_pix_out_if pix_out_bus ();

    luma_unsharp_mask_roi_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_in_bus),
        .o_pix      (pix_out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lumroi_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_in_bus),
        .i_res        (pix_out_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            pix_out_bus.ready = 1'b0;
            hold_left--;
        end else begin
            pix_out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_FRAME_WIDTH)  cur_w_raw = value[12:0];
        if (idx == CFG_FRAME_HEIGHT) cur_h_raw = value[12:0];
        if (idx == CFG_LUMA_LANE)    cur_lane  = value[0];
    endtask

    task automatic program_regs(input int unsigned w, input int unsigned h,
                                input int unsigned str, input int unsigned bg,
                                input int unsigned thr, input int unsigned rc,
                                input int unsigned rr, input int unsigned lane);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_STRENGTH, str);
        write_reg(CFG_BG_SCALE, bg);
        write_reg(CFG_THRESHOLDS, thr);
        write_reg(CFG_ROI_COLUMNS, rc);
        write_reg(CFG_ROI_ROWS, rr);
        write_reg(CFG_LUMA_LANE, lane);
    endtask

    function automatic int unsigned pick_roi(input int unsigned span);
        int unsigned lo, hi;
        case ($urandom_range(19))
            0:       return 0;
            1:       return 26'h3FFFFFF;
            2, 3:    return $urandom & 26'h3FFFFFF;
            default: begin
                lo = $urandom_range(span);
                hi = $urandom_range(span + 1);
                return {hi[12:0], lo[12:0]};
            end
        endcase
    endfunction

    task automatic random_program(input int unsigned w, input int unsigned h);
        int unsigned str, bg, thr, we, he;
        we = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
        he = (h == 0) ? 1 : h;
        case ($urandom_range(9))
            0:       str = 0;
            1:       str = 2;
            2:       str = 3;
            3:       str = 511;
            4:       str = 256;
            default: str = $urandom_range(511);
        endcase
        case ($urandom_range(9))
            0:       bg = 0;
            1:       bg = 2;
            2:       bg = 256;
            3:       bg = $urandom_range(511, 257);
            default: bg = $urandom_range(256);
        endcase
        case ($urandom_range(5))
            0:       thr = 0;
            1:       thr = 16'hFFFF;
            2:       thr = $urandom & 16'hFFFF;
            default: thr = ($urandom_range(60) << 8) | $urandom_range(60);
        endcase
        program_regs(w, h, str, bg, thr, pick_roi(we), pick_roi(he), $urandom_range(1));
    endtask

    task automatic settle();
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_item(input logic [PIX_W-1:0] word, input logic fl);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        pix_in_bus.valid      = 1'b1;
        pix_in_bus.pixel_word = word;
        pix_in_bus.flush      = fl;
        @(posedge clk);
        while (!pix_in_bus.ready) @(posedge clk);
        @(negedge clk);
        pix_in_bus.valid = 1'b0;
    endtask

    // one whole frame plus its drain row under the current sizes
    task automatic send_frame(input int style, input int pause_at, input int hold_at,
                              output int n_sent);
        int unsigned     we, he, base;
        logic [7:0]      luma, chroma;
        logic            fl;
        we     = (cur_w_raw == 0) ? 1 :
                 ((cur_w_raw > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_w_raw);
        he     = (cur_h_raw == 0) ? 1 : cur_h_raw;
        base   = $urandom_range(255);
        n_sent = 0;
        for (int unsigned y = 0; y <= he; y++) begin
            for (int unsigned x = 0; x < we; x++) begin
                if (n_sent == pause_at) begin
                    wait (pending_count == 0);
                    @(negedge clk);
                end
                if (n_sent == hold_at) hold_request = HOLD_CYCLES;
                case (style)
                    0: luma = 8'($urandom);
                    1: luma = 8'(base + $urandom_range(6) - 3);
                    2: luma = ((x + y) % 2 != 0) ? 8'hFF : 8'h00;
                    default: begin
                        case ($urandom_range(4))
                            0:       luma = 8'h00;
                            1:       luma = 8'h01;
                            2:       luma = 8'hFE;
                            3:       luma = 8'hFF;
                            default: luma = 8'($urandom);
                        endcase
                    end
                endcase
                chroma = 8'($urandom);
                if (y == he) fl = ($urandom_range(9) != 0);
                else         fl = ($urandom_range(29) == 0);
                send_item(cur_lane ? {luma, chroma} : {chroma, luma}, fl);
                n_sent++;
            end
        end
    endtask

    initial begin
        int n_sent;
        int frame_idx;
        int unsigned w, h;

        pix_in_bus.valid      = 1'b0;
        pix_in_bus.pixel_word = '0;
        pix_in_bus.flush      = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tiny frame: ROI on one interior pixel, focus threshold at its luma
        program_regs(4, 3, 511, 128, 16'h0080, (2 << 13) | 1, (2 << 13) | 1, 0);
        for (int i = 0; i < 12; i++)
            send_item(EDGE_WORDS[i], (i == 5));
        for (int i = 0; i < 4; i++)
            send_item(PIX_W'($urandom), (i != 1));
        settle();

        // zero sizes act as 1x1, high luma lane
        program_regs(0, 0, 3, 256, 0, 0, 0, 1);
        send_item(16'hA55A, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();

        // narrow frame, register extremes
        program_regs(2, 3, 256, 0, 16'hFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 0);
        send_frame(0, -1, -1, n_sent);

        frame_idx = 0;
        while (random_items < RANDOM_ITEMS || frame_idx < MIN_FRAMES) begin
            settle();
            case (frame_idx % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
            h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
            if (frame_idx == 4) begin w = 12; h = 8; end
            if (frame_idx == 6) begin w = 6;  h = 5; end
            random_program(w, h);
            send_frame($urandom_range(3), (frame_idx == 6) ? 15 : -1,
                       (frame_idx == 4) ? 20 : -1, n_sent);
            random_items += n_sent;
            frame_idx++;
        end

        // shrink the frame in mid-row: counters saturate into the drain row
        settle();
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        random_program(8, 6);
        for (int i = 0; i < 29; i++)
            send_item(PIX_W'($urandom), 1'b0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 4);
        write_reg(CFG_FRAME_HEIGHT, 3);
        send_item(PIX_W'($urandom), 1'b0);
        send_frame(0, -1, -1, n_sent);

        // oversize width, cut short in mid-row, then a zero-width frame
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_program(8191, 1);
        for (int i = 0; i < 5; i++)
            send_item(PIX_W'($urandom), 1'b0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 3);
        for (int i = 0; i < 4; i++)
            send_item(PIX_W'($urandom), (i != 0));
        settle();
        random_program(0, 9);
        send_frame(3, -1, -1, n_sent);

        wait (pending_count == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
